[sv/c2d_pkg.sv]
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants for the fixed point 2D convolution unit.
// ----------------------------------------------------------------------------
package c2d_pkg;

   // Defaults of the top level parameters
   localparam int DEF_MAX_DIM      = 64;
   localparam int DEF_MAX_IN_CH    = 8;
   localparam int DEF_MAX_OUT_CH   = 8;
   localparam int DEF_WEIGHT_DEPTH = 1024;

   // Fixed widths of the transaction fields
   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 15;
   localparam int VALUE_W  = 12;
   localparam int OCH_W    = 3;
   localparam int POS_W    = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 7;

   // Widths of effective configuration and queue payload
   localparam int DIM_W   = 8;   // up to 128
   localparam int CH_W    = 7;   // up to 64
   localparam int WB_W    = 16;  // weight base address
   localparam int RB_W0   = 18;  // signed row offset
   localparam int COORD_W = 8;   // signed tap coordinate
   localparam int PROD_W  = 2 * VALUE_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int OUT_DEPTH   = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD_PIXEL  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_CH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_CH  = 3'd4;

   typedef enum logic [1:0] {
      OP_LOAD_PIXEL,
      OP_LOAD_WEIGHT,
      OP_COMPUTE
   } op_type;

   // Effective (clamped) configuration
   typedef struct packed {
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] width;
      logic [1:0]       kernel;
      logic [CH_W-1:0]  in_ch;
      logic [CH_W-1:0]  out_ch;
   } cfg_type;

   // One classified transaction waiting for the back end
   typedef struct packed {
      op_type                     op;
      logic [INDEX_W-1:0]         addr;
      logic [VALUE_W-1:0]         value;
      logic [WB_W-1:0]            wbase;
      logic signed [RB_W0-1:0]    row_off;
      logic signed [COORD_W-1:0]  row0;
      logic signed [COORD_W-1:0]  col0;
   } entry_type;

   // Back end status
   typedef struct packed {
      logic       idle;
      logic [1:0] out_count;
   } bk_stat_type;

endpackage

[sv/c2d_cmd_queue.sv]
// ----------------------------------------------------------------------------
// c2d_cmd_queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module c2d_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  c2d_pkg::entry_type  push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output c2d_pkg::entry_type  head
);
   import c2d_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   entry_type                  slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign full  = (count_ff == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/c2d_front.sv]
// ----------------------------------------------------------------------------
// c2d_front
// Classifies incoming transactions and precomputes compute start addresses.
// ----------------------------------------------------------------------------
module c2d_front #(
   parameter int MAX_IN_CH    = c2d_pkg::DEF_MAX_IN_CH,
   parameter int MAX_DIM      = c2d_pkg::DEF_MAX_DIM,
   parameter int WEIGHT_DEPTH = c2d_pkg::DEF_WEIGHT_DEPTH
) (
   input  c2d_pkg::cfg_type                  cfg,
   input  logic [c2d_pkg::CMD_W-1:0]         command,
   input  logic [c2d_pkg::INDEX_W-1:0]       load_index,
   input  logic signed [c2d_pkg::VALUE_W-1:0] load_value,
   input  logic [c2d_pkg::OCH_W-1:0]         out_channel,
   input  logic [c2d_pkg::POS_W-1:0]         out_row,
   input  logic [c2d_pkg::POS_W-1:0]         out_col,
   output logic                              keep,
   output c2d_pkg::entry_type                entry
);
   import c2d_pkg::*;

   localparam int PIXEL_DEPTH = MAX_IN_CH * MAX_DIM * MAX_DIM;

   logic                       pix_ok, wt_ok, cmp_ok;
   logic [COORD_W-1:0]         off;
   logic [3:0]                 kk;
   logic [10:0]                ch_span;
   logic signed [COORD_W-1:0]  r0, c0;
   logic signed [RB_W0-1:0]    row_off;

   // Range checks per command
   always_comb begin
      pix_ok = (32'(load_index) < PIXEL_DEPTH);
      wt_ok  = (32'(load_index) < WEIGHT_DEPTH);
      cmp_ok = ({4'd0, out_channel} < cfg.out_ch) &&
               ({2'd0, out_row} < cfg.height) &&
               ({2'd0, out_col} < cfg.width);
   end

   // Start coordinates and base addresses of a compute
   always_comb begin
      off     = (cfg.kernel == 2'd3) ? COORD_W'(1) : '0;
      kk      = (cfg.kernel == 2'd3) ? 4'd9 : 4'd1;
      ch_span = 11'(cfg.in_ch * kk);
      r0      = $signed(COORD_W'(out_row) - off);
      c0      = $signed(COORD_W'(out_col) - off);
      row_off = RB_W0'(r0 * $signed({1'b0, cfg.width}));
   end

   // Classify and drop what has no effect
   always_comb begin
      entry.op      = OP_COMPUTE;
      entry.addr    = load_index;
      entry.value   = load_value;
      entry.wbase   = WB_W'(out_channel * ch_span);
      entry.row_off = row_off;
      entry.row0    = r0;
      entry.col0    = c0;
      keep          = 1'b0;
      unique case (command)
         CMD_LOAD_PIXEL: begin
            entry.op = OP_LOAD_PIXEL;
            keep     = pix_ok;
         end
         CMD_LOAD_WEIGHT: begin
            entry.op = OP_LOAD_WEIGHT;
            keep     = wt_ok;
         end
         CMD_COMPUTE: begin
            entry.op = OP_COMPUTE;
            keep     = cmp_ok;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

endmodule

[sv/c2d_back.sv]
// ----------------------------------------------------------------------------
// c2d_back
// Executes loads and runs the multiply-accumulate sweep of a compute.
// ----------------------------------------------------------------------------
module c2d_back #(
   parameter int MAX_IN_CH    = c2d_pkg::DEF_MAX_IN_CH,
   parameter int MAX_DIM      = c2d_pkg::DEF_MAX_DIM,
   parameter int WEIGHT_DEPTH = c2d_pkg::DEF_WEIGHT_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  c2d_pkg::cfg_type                   cfg,
   input  logic                               q_empty,
   input  c2d_pkg::entry_type                 q_head,
   output logic                               q_pop,
   input  logic                               rsp_pop,
   output logic                               rsp_empty,
   output logic signed [c2d_pkg::VALUE_W-1:0] rsp_result_value,
   output c2d_pkg::bk_stat_type               stat
);
   import c2d_pkg::*;

   localparam int PIXEL_DEPTH = MAX_IN_CH * MAX_DIM * MAX_DIM;
   localparam int PA_W  = $clog2(PIXEL_DEPTH);
   localparam int WA_W  = $clog2(WEIGHT_DEPTH);
   localparam int RB_W  = PA_W + 2;
   localparam int OP_W  = $clog2(OUT_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN,
      S_DONE
   } state_type;

   // Memories
   logic [VALUE_W-1:0] pix_mem [PIXEL_DEPTH];
   logic [VALUE_W-1:0] wt_mem  [WEIGHT_DEPTH];

   // Sequencer
   state_type                 state_ff, state_in;
   logic [CH_W-1:0]           ic_ff, ic_in;
   logic [1:0]                ky_ff, ky_in, kx_ff, kx_in;
   logic signed [COORD_W-1:0] r_ff, r_in, c_ff, c_in;
   logic signed [COORD_W-1:0] r0_ff, r0_in, c0_ff, c0_in;
   logic signed [RB_W-1:0]    ch_base_ff, ch_base_in;
   logic signed [RB_W-1:0]    row_base_ff, row_base_in;
   logic signed [RB_W-1:0]    row_off_ff, row_off_in;
   logic [WB_W-1:0]           widx_ff, widx_in;
   logic signed [RB_W-1:0]    hw_ff;

   // Tap pipeline
   logic                      v1_ff, last1_ff, okp_ff, okw_ff;
   logic [VALUE_W-1:0]        pix_rd_ff, wt_rd_ff;
   logic                      v2_ff, last2_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [VALUE_W-1:0]        acc_ff;

   // Result buffer
   logic [VALUE_W-1:0]        out_ff [OUT_DEPTH];
   logic [OP_W-1:0]           out_wr_ff, out_rd_ff;
   logic [1:0]                out_cnt_ff;

   logic                      issue, last_tap, tap_in_img, wt_in_store;
   logic                      pix_we, wt_we, out_push, out_pop, start;
   logic signed [RB_W-1:0]    paddr_s;
   logic [PA_W-1:0]           pix_raddr, pix_waddr;
   logic [WA_W-1:0]           wt_raddr, wt_waddr;
   logic [1:0]                km1;
   logic signed [PROD_W-1:0]  p_op, w_op;

   assign km1 = cfg.kernel - 2'd1;

   // Tap decode
   always_comb begin
      issue      = (state_ff == S_RUN);
      last_tap   = (ic_ff == cfg.in_ch - 1'b1) && (ky_ff == km1) && (kx_ff == km1);
      tap_in_img = (r_ff >= 0) && (c_ff >= 0) &&
                   ($signed({1'b0, r_ff}) < $signed({1'b0, cfg.height})) &&
                   ($signed({1'b0, c_ff}) < $signed({1'b0, cfg.width}));
      wt_in_store = (32'(widx_ff) < WEIGHT_DEPTH);
      paddr_s    = row_base_ff + RB_W'(c_ff);
      pix_raddr  = paddr_s[PA_W-1:0];
      wt_raddr   = widx_ff[WA_W-1:0];
      start      = (state_ff == S_IDLE) && !q_empty;
      pix_we     = start && (q_head.op == OP_LOAD_PIXEL);
      wt_we      = start && (q_head.op == OP_LOAD_WEIGHT);
      pix_waddr  = PA_W'({17'd0, q_head.addr});
      wt_waddr   = WA_W'({17'd0, q_head.addr});
      out_push   = (state_ff == S_DONE) && (out_cnt_ff != 2'(OUT_DEPTH));
      out_pop    = rsp_pop && !rsp_empty;
   end

   assign q_pop = start;

   // Sequencer next state: walk input channels, kernel rows, kernel columns
   always_comb begin
      state_in    = state_ff;
      ic_in       = ic_ff;
      ky_in       = ky_ff;
      kx_in       = kx_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      r0_in       = r0_ff;
      c0_in       = c0_ff;
      ch_base_in  = ch_base_ff;
      row_base_in = row_base_ff;
      row_off_in  = row_off_ff;
      widx_in     = widx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && (q_head.op == OP_COMPUTE)) begin
               state_in    = S_RUN;
               ic_in       = '0;
               ky_in       = '0;
               kx_in       = '0;
               r_in        = q_head.row0;
               c_in        = q_head.col0;
               r0_in       = q_head.row0;
               c0_in       = q_head.col0;
               ch_base_in  = '0;
               row_off_in  = RB_W'(q_head.row_off);
               row_base_in = RB_W'(q_head.row_off);
               widx_in     = q_head.wbase;
            end
         end
         S_RUN: begin
            widx_in = widx_ff + 1'b1;
            if (last_tap) begin
               state_in = S_DRAIN;
            end else if (kx_ff != km1) begin
               kx_in = kx_ff + 1'b1;
               c_in  = c_ff + $signed(COORD_W'(1));
            end else if (ky_ff != km1) begin
               kx_in       = '0;
               c_in        = c0_ff;
               ky_in       = ky_ff + 1'b1;
               r_in        = r_ff + $signed(COORD_W'(1));
               row_base_in = row_base_ff + RB_W'($signed({1'b0, cfg.width}));
            end else begin
               kx_in       = '0;
               c_in        = c0_ff;
               ky_in       = '0;
               r_in        = r0_ff;
               ic_in       = ic_ff + 1'b1;
               ch_base_in  = ch_base_ff + hw_ff;
               row_base_in = ch_base_ff + hw_ff + row_off_ff;
            end
         end
         S_DRAIN: begin
            if (v2_ff && last2_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_push) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ic_ff       <= ic_in;
      ky_ff       <= ky_in;
      kx_ff       <= kx_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      r0_ff       <= r0_in;
      c0_ff       <= c0_in;
      ch_base_ff  <= ch_base_in;
      row_base_ff <= row_base_in;
      row_off_ff  <= row_off_in;
      widx_ff     <= widx_in;
   end

   // Channel plane size, stable while configuration holds
   always_ff @(posedge clock) begin
      hw_ff <= $signed(RB_W'(cfg.height * cfg.width));
   end

   // Pixel and weight stores
   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[pix_waddr] <= q_head.value;
      end
      pix_rd_ff <= pix_mem[pix_raddr];
   end

   always_ff @(posedge clock) begin
      if (wt_we) begin
         wt_mem[wt_waddr] <= q_head.value;
      end
      wt_rd_ff <= wt_mem[wt_raddr];
   end

   // Tap pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
      last1_ff <= last_tap;
      okp_ff   <= tap_in_img;
      okw_ff   <= wt_in_store;
      last2_ff <= last1_ff;
   end

   // Multiply masked operands
   always_comb begin
      p_op = okp_ff ? PROD_W'($signed(pix_rd_ff)) : '0;
      w_op = okw_ff ? PROD_W'($signed(wt_rd_ff)) : '0;
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(p_op * w_op);
   end

   // Accumulate floored product with wraparound
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + prod_ff[VALUE_W+3:4];
      end
   end

   // Result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (out_push) begin
            out_wr_ff <= out_wr_ff + 1'b1;
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + 1'b1;
         end
         if (out_push && !out_pop) begin
            out_cnt_ff <= out_cnt_ff + 1'b1;
         end else if (out_pop && !out_push) begin
            out_cnt_ff <= out_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[out_wr_ff] <= acc_ff;
      end
   end

   assign rsp_empty        = (out_cnt_ff == '0);
   assign rsp_result_value = $signed(out_ff[out_rd_ff]);
   assign stat.idle        = (state_ff == S_IDLE);
   assign stat.out_count   = out_cnt_ff;

endmodule

[sv/conv2d_same_padding_fixed_unit.sv]
// ----------------------------------------------------------------------------
// conv2d_same_padding_fixed_unit
// Multichannel 3x3 or 1x1 convolution with zero same padding, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Push a transaction on req_* while req_full is low. Command 0 loads a pixel,
//   command 1 loads a weight, command 2 computes one output pixel; other
//   commands and out of range loads or outputs are dropped.
//   Results appear on rsp_result_value while rsp_empty is low; pop them with
//   rsp_pop. Only compute transactions give a result.
//   A two entry queue separates intake from execution, so intake continues
//   while the back end works or while results wait to be popped.
//   Loads are done in the back end straight from the queue head. A compute
//   walks N = input_channels * taps (9 taps for 3x3, 1 for 1x1), one tap per
//   cycle through the shared multiplier, after a start step and followed by the
//   pipeline drain and the result write; N is 27 after reset and at most 72.
//   A two entry result buffer holds finished results; when it is full the
//   back end holds its result and stops.
//   Reset (synchronous) empties both queues and sets registers to their
//   defaults; the pixel and weight stores are not cleared.
//   Write registers via csr_* only while no transaction is in flight.
// ----------------------------------------------------------------------------
module conv2d_same_padding_fixed_unit #(
   parameter int MAX_DIM      = c2d_pkg::DEF_MAX_DIM,
   parameter int MAX_IN_CH    = c2d_pkg::DEF_MAX_IN_CH,
   parameter int MAX_OUT_CH   = c2d_pkg::DEF_MAX_OUT_CH,
   parameter int WEIGHT_DEPTH = c2d_pkg::DEF_WEIGHT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [c2d_pkg::CMD_W-1:0]           req_command,
   input  logic [c2d_pkg::INDEX_W-1:0]         req_load_index,
   input  logic signed [c2d_pkg::VALUE_W-1:0]  req_load_value,
   input  logic [c2d_pkg::OCH_W-1:0]           req_out_channel,
   input  logic [c2d_pkg::POS_W-1:0]           req_out_row,
   input  logic [c2d_pkg::POS_W-1:0]           req_out_col,
   input  logic                                rsp_pop,
   output logic                                rsp_empty,
   output logic signed [c2d_pkg::VALUE_W-1:0]  rsp_result_value,
   input  logic                                csr_write_enable,
   input  logic [c2d_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [c2d_pkg::CSR_DAT_W-1:0]       csr_write_data
);
   import c2d_pkg::*;

   logic [6:0]   height_ff, width_ff;
   logic [1:0]   kernel_ff;
   logic [3:0]   in_ch_ff, out_ch_ff;
   cfg_type      cfg;
   logic         keep, q_push, q_full, q_pop, q_empty;
   entry_type    entry, q_head;
   bk_stat_type  stat;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= 7'd64;
         width_ff  <= 7'd64;
         kernel_ff <= 2'd3;
         in_ch_ff  <= 4'd3;
         out_ch_ff <= 4'd8;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEIGHT: height_ff <= csr_write_data;
            CSR_WIDTH:  width_ff  <= csr_write_data;
            CSR_KERNEL: kernel_ff <= csr_write_data[1:0];
            CSR_IN_CH:  in_ch_ff  <= csr_write_data[3:0];
            CSR_OUT_CH: out_ch_ff <= csr_write_data[3:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp registers to usable values
   always_comb begin
      cfg.height = (height_ff == '0) ? DIM_W'(1) :
                   ({1'b0, height_ff} > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) :
                   {1'b0, height_ff};
      cfg.width  = (width_ff == '0) ? DIM_W'(1) :
                   ({1'b0, width_ff} > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) :
                   {1'b0, width_ff};
      cfg.kernel = (kernel_ff <= 2'd1) ? 2'd1 : 2'd3;
      cfg.in_ch  = (in_ch_ff == '0) ? CH_W'(1) :
                   (CH_W'(in_ch_ff) > CH_W'(MAX_IN_CH)) ? CH_W'(MAX_IN_CH) :
                   CH_W'(in_ch_ff);
      cfg.out_ch = (out_ch_ff == '0) ? CH_W'(1) :
                   (CH_W'(out_ch_ff) > CH_W'(MAX_OUT_CH)) ? CH_W'(MAX_OUT_CH) :
                   CH_W'(out_ch_ff);
   end

   c2d_front #(
      .MAX_IN_CH    (MAX_IN_CH),
      .MAX_DIM      (MAX_DIM),
      .WEIGHT_DEPTH (WEIGHT_DEPTH)
   ) u_front (
      .cfg         (cfg),
      .command     (req_command),
      .load_index  (req_load_index),
      .load_value  (req_load_value),
      .out_channel (req_out_channel),
      .out_row     (req_out_row),
      .out_col     (req_out_col),
      .keep        (keep),
      .entry       (entry)
   );

   assign req_full = q_full;
   assign q_push   = req_push && !q_full && keep;

   c2d_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (entry),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   c2d_back #(
      .MAX_IN_CH    (MAX_IN_CH),
      .MAX_DIM      (MAX_DIM),
      .WEIGHT_DEPTH (WEIGHT_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_result_value (rsp_result_value),
      .stat             (stat)
   );

   // Result buffer never overflows
   assert property (@(posedge clock) disable iff (reset)
      stat.out_count <= 2'(OUT_DEPTH))
      else $error("result buffer overflow");

   // Queue is only popped while the back end is idle
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (stat.idle && !q_empty))
      else $error("queue popped while back end busy");

   // A transaction dropped at intake never reaches the queue
   assert property (@(posedge clock) disable iff (reset)
      (req_push && !q_full && !keep) |=> ($past(q_empty) |-> q_empty || $past(q_pop)))
      else $error("dropped transaction entered queue");

endmodule
